// File: rtl/core/ueme_pkg.sv
// ============================================================================
// ueme_pkg
// Shared types, constants and character tables for the UTF-16 emoji markup
// escaper: code point classes, the work plan of one transfer, and helpers.
// ============================================================================
`default_nettype none

package ueme_pkg;

    // surrogate ranges
    localparam logic [15:0] HIGH_SURR_FIRST = 16'hD800;
    localparam logic [15:0] HIGH_SURR_LAST  = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_FIRST  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_LAST   = 16'hDFFF;

    // dropped code points
    localparam logic [20:0] CP_ZWJ       = 21'h0200D;
    localparam logic [20:0] CP_VS15      = 21'h0FE0E;
    localparam logic [20:0] CP_VS16      = 21'h0FE0F;
    localparam logic [20:0] CP_TONE_LO   = 21'h1F3FB;
    localparam logic [20:0] CP_TONE_HI   = 21'h1F3FF;

    // escaped characters
    localparam logic [20:0] CP_LT        = 21'h0003C;
    localparam logic [20:0] CP_GT        = 21'h0003E;
    localparam logic [20:0] CP_AMP       = 21'h00026;

    // length of the fixed tag text before the hex digits
    localparam logic [4:0] TAG_PREFIX_LEN = 5'd11;

    // what the body of one transfer emits
    typedef enum logic [2:0] {
        K_NONE,
        K_UNIT,
        K_PAIR,
        K_TAG,
        K_LT,
        K_GT,
        K_AMP
    } t_kind;

    // work plan of one input transfer
    typedef struct packed {
        logic        has_flush;
        logic [15:0] flush_unit;
        t_kind       kind;
        logic [15:0] u0;
        logic [15:0] u1;
        logic [19:0] cp;
    } t_plan;

    // emitter status seen by the top level
    typedef struct packed {
        logic busy;
        logic ready;
    } t_emit_status;

    function automatic logic in_emoji(logic [20:0] cp);
        return (cp >= 21'h1F300 && cp <= 21'h1FAFF) ||
               (cp >= 21'h1F000 && cp <= 21'h1F2FF) ||
               (cp >= 21'h02600 && cp <= 21'h027BF) ||
               (cp >= 21'h02B00 && cp <= 21'h02BFF) ||
               (cp >= 21'h02190 && cp <= 21'h021FF) ||
               (cp >= 21'h02300 && cp <= 21'h023FF);
    endfunction

    function automatic t_kind classify(logic [20:0] cp, logic pair);
        t_kind k;
        if (cp == CP_ZWJ || cp == CP_VS15 || cp == CP_VS16 ||
            (cp >= CP_TONE_LO && cp <= CP_TONE_HI)) begin
            k = K_NONE;
        end else if (in_emoji(cp)) begin
            k = K_TAG;
        end else if (cp == CP_LT) begin
            k = K_LT;
        end else if (cp == CP_GT) begin
            k = K_GT;
        end else if (cp == CP_AMP) begin
            k = K_AMP;
        end else if (pair) begin
            k = K_PAIR;
        end else begin
            k = K_UNIT;
        end
        return k;
    endfunction

    // number of body units; five selects a five-digit hex value
    function automatic logic [4:0] body_len(t_kind kind, logic five);
        logic [4:0] n;
        case (kind)
            K_UNIT:  n = 5'd1;
            K_PAIR:  n = 5'd2;
            K_TAG:   n = five ? 5'd19 : 5'd18;
            K_LT:    n = 5'd4;
            K_GT:    n = 5'd4;
            K_AMP:   n = 5'd5;
            default: n = 5'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] hex_char(logic [3:0] nib);
        return (nib < 4'd10) ? (8'h30 + {4'd0, nib}) : (8'h57 + {4'd0, nib});
    endfunction

    // one unit of the image tag at position pos
    function automatic logic [15:0] tag_unit(logic [19:0] cp, logic five, logic [4:0] pos);
        logic [4:0] ndig;
        logic [4:0] hpos;
        logic [4:0] tpos;
        logic [2:0] nib_idx;
        logic [3:0] nib;
        logic [7:0] ch;
        ndig    = five ? 5'd5 : 5'd4;
        hpos    = pos - TAG_PREFIX_LEN;
        tpos    = hpos - ndig;
        nib_idx = 3'(ndig - 5'd1 - hpos);
        nib     = 4'(cp >> {nib_idx, 2'b00});
        if (pos < TAG_PREFIX_LEN) begin
            case (pos[3:0])
                4'd0:    ch = 8'h3C;  // <
                4'd1:    ch = 8'h69;  // i
                4'd2:    ch = 8'h6D;  // m
                4'd3:    ch = 8'h67;  // g
                4'd4:    ch = 8'h20;  // space
                4'd5:    ch = 8'h69;  // i
                4'd6:    ch = 8'h64;  // d
                4'd7:    ch = 8'h3D;  // =
                4'd8:    ch = 8'h22;  // quote
                4'd9:    ch = 8'h65;  // e
                default: ch = 8'h5F;  // _
            endcase
        end else if (hpos < ndig) begin
            ch = hex_char(nib);
        end else begin
            case (tpos[1:0])
                2'd0:    ch = 8'h22;  // quote
                2'd1:    ch = 8'h2F;  // /
                default: ch = 8'h3E;  // >
            endcase
        end
        return {8'd0, ch};
    endfunction

    // one unit of the body at position pos
    function automatic logic [15:0] body_unit(t_kind kind, logic [15:0] u0, logic [15:0] u1,
                                              logic [19:0] cp, logic [4:0] pos);
        logic [7:0]  ch;
        logic [15:0] u;
        ch = 8'h00;
        case (kind)
            K_LT: begin
                case (pos[1:0])
                    2'd0:    ch = 8'h26;
                    2'd1:    ch = 8'h6C;
                    2'd2:    ch = 8'h74;
                    default: ch = 8'h3B;
                endcase
            end
            K_GT: begin
                case (pos[1:0])
                    2'd0:    ch = 8'h26;
                    2'd1:    ch = 8'h67;
                    2'd2:    ch = 8'h74;
                    default: ch = 8'h3B;
                endcase
            end
            K_AMP: begin
                case (pos[2:0])
                    3'd0:    ch = 8'h26;
                    3'd1:    ch = 8'h61;
                    3'd2:    ch = 8'h6D;
                    3'd3:    ch = 8'h70;
                    default: ch = 8'h3B;
                endcase
            end
            default: ch = 8'h00;
        endcase
        case (kind)
            K_UNIT:  u = u0;
            K_PAIR:  u = (pos == 5'd0) ? u0 : u1;
            K_TAG:   u = tag_unit(cp, cp[16], pos);
            default: u = {8'd0, ch};
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

// File: rtl/core/ueme_decode.sv
// ============================================================================
// ueme_decode
// Surrogate pairing and code point classification; holds a pending high
// surrogate and builds the work plan for each input transfer.
// ============================================================================
`default_nettype none

module ueme_decode (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_accept,
    input  wire logic [15:0]     i_unit,
    input  wire logic            i_eom,
    output ueme_pkg::t_plan      o_plan,
    output logic                 o_held_valid
);

    logic [15:0] r_held_high;
    logic        r_held_valid;
    logic [15:0] n_held_high;
    logic        n_held_valid;

    logic        is_high;
    logic        is_low;
    logic [20:0] pair_cp;

    // unit classes and joined code point
    assign is_high = (i_unit >= ueme_pkg::HIGH_SURR_FIRST) &&
                     (i_unit <= ueme_pkg::HIGH_SURR_LAST);
    assign is_low  = (i_unit >= ueme_pkg::LOW_SURR_FIRST) &&
                     (i_unit <= ueme_pkg::LOW_SURR_LAST);
    assign pair_cp = {1'b0, r_held_high[9:0], i_unit[9:0]} + 21'h10000;

    // plan and next held state
    always_comb begin
        o_plan            = '0;
        o_plan.kind       = ueme_pkg::K_NONE;
        o_plan.u0         = i_unit;
        o_plan.flush_unit = r_held_high;
        n_held_high       = r_held_high;
        n_held_valid      = r_held_valid;
        if (r_held_valid && is_low) begin
            o_plan.kind  = ueme_pkg::classify(pair_cp, 1'b1);
            o_plan.u0    = r_held_high;
            o_plan.u1    = i_unit;
            o_plan.cp    = pair_cp[19:0];
            n_held_high  = '0;
            n_held_valid = 1'b0;
        end else begin
            o_plan.has_flush = r_held_valid;
            n_held_high      = '0;
            n_held_valid     = 1'b0;
            if (is_high) begin
                if (i_eom) begin
                    o_plan.kind = ueme_pkg::K_UNIT;
                end else begin
                    n_held_high  = i_unit;
                    n_held_valid = 1'b1;
                end
            end else begin
                o_plan.kind = ueme_pkg::classify({5'd0, i_unit}, 1'b0);
                o_plan.cp   = {4'd0, i_unit};
            end
        end
    end

    // held surrogate register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_high  <= '0;
            r_held_valid <= 1'b0;
        end else if (i_accept) begin
            r_held_high  <= n_held_high;
            r_held_valid <= n_held_valid;
        end
    end

    assign o_held_valid = r_held_valid;

endmodule

`default_nettype wire

// File: rtl/core/ueme_emit.sv
// ============================================================================
// ueme_emit
// Plan register and output sequencer: walks the flushed unit and the body
// of one plan into the output register, one unit per cycle unless the output stalls.
// ============================================================================
`default_nettype none

module ueme_emit (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  ueme_pkg::t_plan       i_plan,
    input  wire logic             i_m_tready,
    output logic                  o_m_tvalid,
    output logic [15:0]           o_m_tdata,
    output logic                  o_m_tlast,
    output ueme_pkg::t_emit_status o_status
);

    logic             r_busy;
    logic             r_flush_pending;
    ueme_pkg::t_kind  r_kind;
    logic [15:0]      r_flush_unit;
    logic [15:0]      r_u0;
    logic [15:0]      r_u1;
    logic [19:0]      r_cp;
    logic [4:0]       r_pos;
    logic             r_out_valid;
    logic [15:0]      r_out_data;
    logic             r_out_last;

    logic             adv;
    logic             load;
    logic [4:0]       len;
    logic [15:0]      cur_unit;
    logic             cur_last;

    // current unit of the plan
    assign len = ueme_pkg::body_len(r_kind, r_cp[16]);
    always_comb begin
        if (r_flush_pending) begin
            cur_unit = r_flush_unit;
            cur_last = (r_kind == ueme_pkg::K_NONE);
        end else begin
            cur_unit = ueme_pkg::body_unit(r_kind, r_u0, r_u1, r_cp, r_pos);
            cur_last = (r_pos == len - 5'd1);
        end
    end

    assign adv  = r_busy && (!r_out_valid || i_m_tready);
    assign load = i_accept && (i_plan.has_flush || i_plan.kind != ueme_pkg::K_NONE);

    assign o_status.busy  = r_busy;
    assign o_status.ready = !r_busy || (adv && cur_last);

    // plan register and sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy          <= 1'b0;
            r_flush_pending <= 1'b0;
            r_kind          <= ueme_pkg::K_NONE;
            r_pos           <= '0;
        end else begin
            if (adv) begin
                if (r_flush_pending) begin
                    r_flush_pending <= 1'b0;
                    if (cur_last) begin
                        r_busy <= 1'b0;
                    end
                end else if (cur_last) begin
                    r_busy <= 1'b0;
                end else begin
                    r_pos <= r_pos + 5'd1;
                end
            end
            if (load) begin
                r_busy          <= 1'b1;
                r_flush_pending <= i_plan.has_flush;
                r_kind          <= i_plan.kind;
                r_pos           <= '0;
            end
        end
    end

    // plan payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_flush_unit <= i_plan.flush_unit;
            r_u0         <= i_plan.u0;
            r_u1         <= i_plan.u1;
            r_cp         <= i_plan.cp;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_data <= cur_unit;
            r_out_last <= cur_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

`default_nettype wire

// File: rtl/core/utf16_emoji_markup_escaper_top.sv
// ============================================================================
// utf16_emoji_markup_escaper_top
// UTF-16 message to rich text: surrogate pairing, emoji image tags,
// markup entity escapes, dropped joiners, selectors and skin tones.
// ============================================================================
//
// channel   dir   tdata              tlast            tuser
// s         in    [15:0] code_unit   end_of_message   -
// m         out   [15:0] out_unit    run_last         -
//
// Each input transfer yields 0 to 19 output units, one per cycle while the
// output is not stalled. A new input is taken in the cycle its predecessor's
// last unit is loaded into the output register.
// Reset (synchronous, active low) clears the held surrogate and the sequencer.
// A stalled output holds a busy sequencer and, with it, the input side.
`default_nettype none

module utf16_emoji_markup_escaper_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [15:0] i_s_tdata,   // [15:0] code_unit
    input  wire logic        i_s_tlast,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [15:0]      o_m_tdata,   // [15:0] out_unit
    output logic             o_m_tlast
);

    logic                    s_accept;
    ueme_pkg::t_plan         plan;
    logic                    held_valid;
    ueme_pkg::t_emit_status  emit_status;

    assign o_s_tready = emit_status.ready;
    assign s_accept   = i_s_tvalid && o_s_tready;

    // surrogate pairing and classification
    ueme_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (s_accept),
        .i_unit       (i_s_tdata),
        .i_eom        (i_s_tlast),
        .o_plan       (plan),
        .o_held_valid (held_valid)
    );

    // output sequencing
    ueme_emit u_emit (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (s_accept),
        .i_plan     (plan),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_status   (emit_status)
    );

`ifndef SYNTHESIS
    // a message end never leaves a surrogate held
    a_eom_clears_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && i_s_tlast) |=> !held_valid)
        else $error("held surrogate left after message end");

    // a high surrogate without message end is held
    a_high_is_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && !i_s_tlast && i_s_tdata >= ueme_pkg::HIGH_SURR_FIRST &&
         i_s_tdata <= ueme_pkg::HIGH_SURR_LAST) |=> held_valid)
        else $error("high surrogate not held");

    // a busy sequencer behind a stalled output takes no input
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (emit_status.busy && o_m_tvalid && !i_m_tready) |-> !o_s_tready)
        else $error("input taken while output stalled");

    // idle sequencer always takes input
    a_idle_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !emit_status.busy |-> o_s_tready)
        else $error("idle sequencer not ready");
`endif

endmodule

`default_nettype wire
